/* hw/rtl/rcfa_pkg.sv */
// Shared types, codes and defaults of the reference-counted frame allocator.
package rcfa_pkg;

  // Default configuration
  localparam int NUM_FRAMES_DEF = 1024;
  localparam int REF_BITS_DEF   = 16;

  // Fixed request and result field widths
  localparam int OPC_W  = 3;
  localparam int FN_W   = 20;
  localparam int STAT_W = 2;

  // Request opcodes
  localparam logic [OPC_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OPC_W-1:0] OP_FREE   = 3'd1;
  localparam logic [OPC_W-1:0] OP_INC    = 3'd2;
  localparam logic [OPC_W-1:0] OP_READ   = 3'd3;
  localparam logic [OPC_W-1:0] OP_DONATE = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] RES_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] RES_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] RES_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] RES_NOCHG = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;  // write one clearing-pass entry
    logic issue;   // request transfer: latch it and start the memory reads
    logic exec;    // apply the update and load the result register
  } rcfa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // clearing pass is at its last entry
  } rcfa_stat_t;

endpackage

/* hw/rtl/rcfa_if.sv */
// Request and result channel interfaces of the frame allocator.
interface rcfa_in_if
  import rcfa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [FN_W-1:0]  frame_number;

  modport source (output valid, output opcode, output frame_number, input ready);
  modport sink   (input valid, input opcode, input frame_number, output ready);
endinterface

interface rcfa_out_if
  import rcfa_pkg::*;
#(
  parameter int FRAME_W = 10,
  parameter int REF_W   = 16,
  parameter int CNT_W   = 11
) ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FRAME_W-1:0] granted_frame;
  logic [REF_W-1:0]  reference_count;
  logic [CNT_W-1:0]  free_frames;
  logic [CNT_W-1:0]  donated_total;

  modport source (output valid, output status, output granted_frame,
                  output reference_count, output free_frames, output donated_total,
                  input ready);
  modport sink   (input valid, input status, input granted_frame,
                  input reference_count, input free_frames, input donated_total,
                  output ready);
endinterface

/* hw/rtl/rcfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rcfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/rcfa_ctrl.sv */
// Controller state machine: clearing pass, request intake and result handoff.
module rcfa_ctrl
  import rcfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  rcfa_stat_t stat,
  output rcfa_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // Result register can take a new result this cycle
  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.issue = in_valid;
      end
      S_EXEC: begin
        cmd.exec = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Result valid: set on update, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/rcfa_datapath.sv */
// Datapath: frame table and free stack memories, counters and result register.
module rcfa_datapath
  import rcfa_pkg::*;
#(
  parameter int  NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int  REF_BITS   = REF_BITS_DEF,
  localparam int FRAME_W    = $clog2(NUM_FRAMES),
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rcfa_cmd_t           cmd,
  output rcfa_stat_t          stat,
  input  logic [OPC_W-1:0]    in_opcode,
  input  logic [FN_W-1:0]     in_frame_number,
  output logic [STAT_W-1:0]   out_status,
  output logic [FRAME_W-1:0]  out_granted_frame,
  output logic [REF_BITS-1:0] out_reference_count,
  output logic [CNT_W-1:0]    out_free_frames,
  output logic [CNT_W-1:0]    out_donated_total
);

  localparam int ENT_W = REF_BITS + 1;
  localparam logic [CNT_W-1:0]    CNT_FULL  = CNT_W'(NUM_FRAMES);
  localparam logic [FN_W:0]       FN_LIMIT  = (FN_W + 1)'(NUM_FRAMES);
  localparam logic [FRAME_W-1:0]  CLR_LAST  = FRAME_W'(NUM_FRAMES - 1);
  localparam logic [REF_BITS-1:0] REF_MAX   = '1;
  localparam logic [REF_BITS-1:0] REF_ZERO  = '0;
  localparam logic [REF_BITS-1:0] REF_ONE   = REF_BITS'(1);
  localparam logic [CNT_W-1:0]    CNT_ONE   = CNT_W'(1);

  // Request latch
  logic [OPC_W-1:0]   op_r;
  logic [FRAME_W-1:0] fn_r;
  logic               bad_r;

  // Bookkeeping
  logic [FRAME_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]   depth_r, depth_nxt;
  logic [CNT_W-1:0]   donated_r, donated_nxt;

  // Result register
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic [FRAME_W-1:0]  granted_r, granted_nxt;
  logic [REF_BITS-1:0] refc_r, refc_nxt;

  // Memory ports
  logic               fr_we;
  logic [FRAME_W-1:0] fr_waddr;
  logic [ENT_W-1:0]   fr_wdata, fr_rdata;
  logic               fl_we;
  logic [FRAME_W-1:0] fl_raddr;
  logic [FRAME_W-1:0] fl_rdata;

  // Update decisions
  logic               upd_we;
  logic [FRAME_W-1:0] upd_addr;
  logic [ENT_W-1:0]   upd_data;
  logic               push;
  logic               cur_in_use;
  logic [REF_BITS-1:0] cur_ref, ref_dec, ref_inc;
  logic [CNT_W-1:0]   depth_dec;

  // Frame table: in-use flag over the reference count
  rcfa_ram #(.WIDTH(ENT_W), .DEPTH(NUM_FRAMES)) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .re    (cmd.issue),
    .raddr (in_frame_number[FRAME_W-1:0]),
    .rdata (fr_rdata)
  );

  // Free stack
  rcfa_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_stack_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (depth_r[FRAME_W-1:0]),
    .wdata (fn_r),
    .re    (cmd.issue),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  assign depth_dec = depth_r - CNT_ONE;
  assign fl_raddr  = depth_dec[FRAME_W-1:0];

  // Clearing pass counter
  assign stat.clr_last = (clr_cnt_r == CLR_LAST);
  assign clr_cnt_nxt   = cmd.clr_wr ? clr_cnt_r + FRAME_W'(1) : clr_cnt_r;

  // Latch the request on transfer
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      op_r  <= in_opcode;
      fn_r  <= in_frame_number[FRAME_W-1:0];
      bad_r <= ({1'b0, in_frame_number} >= FN_LIMIT);
    end
  end

  assign cur_in_use = fr_rdata[REF_BITS];
  assign cur_ref    = fr_rdata[REF_BITS-1:0];
  assign ref_dec    = cur_ref - REF_ONE;
  assign ref_inc    = cur_ref + REF_ONE;

  // Decide the update and the result
  always_comb begin
    upd_we      = 1'b0;
    upd_addr    = fn_r;
    upd_data    = fr_rdata;
    push        = 1'b0;
    status_nxt  = RES_DONE;
    granted_nxt = '0;
    refc_nxt    = REF_ZERO;
    depth_nxt   = depth_r;
    donated_nxt = donated_r;
    if (op_r == OP_ALLOC) begin
      if (depth_r == '0) begin
        status_nxt = RES_EMPTY;
      end else begin
        upd_we      = 1'b1;
        upd_addr    = fl_rdata;
        upd_data    = {1'b1, REF_ONE};
        depth_nxt   = depth_dec;
        granted_nxt = fl_rdata;
        refc_nxt    = REF_ONE;
      end
    end else if (op_r == OP_FREE || op_r == OP_INC || op_r == OP_READ ||
                 op_r == OP_DONATE) begin
      if (bad_r) begin
        status_nxt = RES_RANGE;
      end else begin
        refc_nxt = cur_ref;
        case (op_r)
          OP_FREE: begin
            if (cur_ref == REF_ZERO) begin
              status_nxt = RES_NOCHG;
            end else begin
              upd_we   = 1'b1;
              refc_nxt = ref_dec;
              if (ref_dec == REF_ZERO && cur_in_use) begin
                upd_data = {1'b0, ref_dec};
                push     = 1'b1;
              end else begin
                upd_data = {cur_in_use, ref_dec};
              end
            end
          end
          OP_INC: begin
            if (cur_ref == REF_MAX) begin
              status_nxt = RES_NOCHG;
            end else begin
              upd_we   = 1'b1;
              upd_data = {cur_in_use, ref_inc};
              refc_nxt = ref_inc;
            end
          end
          OP_DONATE: begin
            if (!cur_in_use) begin
              status_nxt = RES_NOCHG;
            end else begin
              upd_we   = 1'b1;
              upd_data = {1'b0, cur_ref};
              push     = 1'b1;
              if (donated_r != CNT_FULL) donated_nxt = donated_r + CNT_ONE;
            end
          end
          default: begin
            status_nxt = RES_DONE;
          end
        endcase
        // Stack never overflows; guard it anyway
        if (push && depth_r != CNT_FULL) begin
          depth_nxt = depth_r + CNT_ONE;
        end else begin
          push = 1'b0;
        end
      end
    end else begin
      status_nxt = RES_NOCHG;
    end
  end

  // Memory write selection: clearing pass or request update
  assign fr_we    = cmd.clr_wr || (cmd.exec && upd_we);
  assign fr_waddr = cmd.clr_wr ? clr_cnt_r : upd_addr;
  assign fr_wdata = cmd.clr_wr ? {1'b1, REF_ZERO} : upd_data;
  assign fl_we    = cmd.exec && push;

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      depth_r   <= '0;
      donated_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      if (cmd.exec) begin
        depth_r   <= depth_nxt;
        donated_r <= donated_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      refc_r    <= refc_nxt;
    end
  end

  assign out_status          = status_r;
  assign out_granted_frame   = granted_r;
  assign out_reference_count = refc_r;
  assign out_free_frames     = depth_r;
  assign out_donated_total   = donated_r;

endmodule

/* hw/rtl/refcounted_frame_allocator_unit.sv */
// Reference-counted page-frame allocator: top level.
//
// In the transfer cycle of a request the reads of the frame table (in-use flag
// and reference count) and of the free stack top start; once the result
// register is free, the update applies the read-modify-write through the
// single write port of each memory and loads the result register. A new
// request is taken on the cycle after the update, while the previous result
// may still wait on the output; no request is taken before the update of the
// one before it. After reset a clearing pass marks every frame in use with a
// zero count; no request is taken during it.
module refcounted_frame_allocator_unit
  import rcfa_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int REF_BITS   = REF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rcfa_in_if.sink   in_ch,
  rcfa_out_if.source out_ch
);

  rcfa_cmd_t  cmd;
  rcfa_stat_t stat;

  rcfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rcfa_datapath #(.NUM_FRAMES(NUM_FRAMES), .REF_BITS(REF_BITS)) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_ch.opcode),
    .in_frame_number     (in_ch.frame_number),
    .out_status          (out_ch.status),
    .out_granted_frame   (out_ch.granted_frame),
    .out_reference_count (out_ch.reference_count),
    .out_free_frames     (out_ch.free_frames),
    .out_donated_total   (out_ch.donated_total)
  );

  // No request transfer while the clearing pass runs
  assert property (@(posedge clk) disable iff (!rst_n) cmd.clr_wr |-> !in_ch.ready)
    else $error("request taken during clearing pass");

  // An update always leaves a valid result behind
  assert property (@(posedge clk) disable iff (!rst_n) cmd.exec |=> out_ch.valid)
    else $error("update did not load the result register");

  // An empty alloc reports an empty stack and grants nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == RES_EMPTY) |->
      (out_ch.free_frames == '0 && out_ch.granted_frame == '0))
    else $error("empty alloc with frames on the stack");

  // The free stack never holds more than all frames
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.free_frames <= NUM_FRAMES))
    else $error("free stack depth beyond frame count");

endmodule

/* tb/tb_refcounted_frame_allocator_unit.sv */
// Testbench of the reference-counted frame allocator: stimulus, prediction and checking.
module tb_refcounted_frame_allocator_unit;
  import rcfa_pkg::*;

  localparam int NUM_FRAMES = NUM_FRAMES_DEF;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int REF_W      = REF_BITS_DEF;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam logic [REF_W-1:0] REF_MAX = '1;

  // Opcodes the block does not define
  localparam logic [OPC_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OPC_W-1:0] OP_RSVD_LAST  = 3'd7;

  // Cycles without any transfer before the run is declared hung; covers the clearing pass
  localparam int STALL_LIMIT = 4 * NUM_FRAMES + 2000;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] granted;
    logic [REF_W-1:0]   refcnt;
    logic [CNT_W-1:0]   free_cnt;
    logic [CNT_W-1:0]   donated;
  } frame_result_t;

  // Predicts allocator results and checks them in order
  class frame_alloc_scoreboard;
    bit                 in_use [NUM_FRAMES];
    logic [REF_W-1:0]   refs [NUM_FRAMES];
    logic [FRAME_W-1:0] stack_slots [NUM_FRAMES];
    int unsigned        depth;
    int unsigned        donated_cnt;
    frame_result_t      expected_q[$];
    logic [FRAME_W-1:0] granted_log[$];
    int unsigned        errors;
    int unsigned        requests;
    int unsigned        results;

    function new();
      foreach (in_use[i]) begin
        in_use[i] = 1'b1;
        refs[i]   = '0;
      end
      depth       = 0;
      donated_cnt = 0;
      errors      = 0;
      requests    = 0;
      results     = 0;
    endfunction

    function void push_free(int unsigned f);
      if (depth < NUM_FRAMES) begin
        stack_slots[depth] = FRAME_W'(f);
        depth++;
      end
    endfunction

    // Apply one accepted request to the shadow state and queue its result
    function void note_request(logic [OPC_W-1:0] op, logic [FN_W-1:0] fn);
      frame_result_t r;
      int unsigned   f;
      r = '0;
      requests++;
      case (op)
        OP_ALLOC: begin
          if (depth == 0) begin
            r.status = RES_EMPTY;
          end else begin
            depth--;
            f         = stack_slots[depth];
            in_use[f] = 1'b1;
            refs[f]   = REF_W'(1);
            r.granted = FRAME_W'(f);
            r.refcnt  = REF_W'(1);
            granted_log.push_back(FRAME_W'(f));
            if (granted_log.size() > 16) void'(granted_log.pop_front());
          end
        end
        OP_FREE, OP_INC, OP_READ, OP_DONATE: begin
          if (fn >= NUM_FRAMES) begin
            r.status = RES_RANGE;
          end else begin
            f = fn;
            case (op)
              OP_FREE: begin
                if (refs[f] == 0) begin
                  r.status = RES_NOCHG;
                end else begin
                  refs[f]--;
                  // last reference gone: release only frames still held
                  if (refs[f] == 0 && in_use[f]) begin
                    in_use[f] = 1'b0;
                    push_free(f);
                  end
                end
              end
              OP_INC: begin
                if (refs[f] == REF_MAX) r.status = RES_NOCHG;
                else refs[f]++;
              end
              OP_DONATE: begin
                if (!in_use[f]) begin
                  r.status = RES_NOCHG;
                end else begin
                  in_use[f] = 1'b0;
                  push_free(f);
                  if (donated_cnt < NUM_FRAMES) donated_cnt++;
                end
              end
              default: ;
            endcase
            r.refcnt = refs[f];
          end
        end
        default: r.status = RES_NOCHG;
      endcase
      r.free_cnt = CNT_W'(depth);
      r.donated  = CNT_W'(donated_cnt);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one result transfer against the oldest prediction
    function void check_result(frame_result_t got);
      frame_result_t want;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("granted_frame", want.granted, got.granted);
      compare_field("reference_count", want.refcnt, got.refcnt);
      compare_field("free_frames", want.free_cnt, got.free_cnt);
      compare_field("donated_total", want.donated, got.donated);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   stall_cycles;
  int unsigned fill_allocs;
  frame_alloc_scoreboard sb;

  rcfa_in_if in_ch ();
  rcfa_out_if #(.FRAME_W(FRAME_W), .REF_W(REF_W), .CNT_W(CNT_W)) out_ch ();

  refcounted_frame_allocator_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side now and then
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 6);
  end

  // Record request transfers
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.opcode, in_ch.frame_number);
  end

  // Check result transfers
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{status:   out_ch.status,
                        granted:  out_ch.granted_frame,
                        refcnt:   out_ch.reference_count,
                        free_cnt: out_ch.free_frames,
                        donated:  out_ch.donated_total});
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one request and hold it until the transfer
  task automatic send_req(input logic [OPC_W-1:0] op, input logic [FN_W-1:0] fn);
    while (!steady && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.frame_number <= fn;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold off until every predicted result has arrived
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [OPC_W-1:0] pick_opcode();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 24) return OP_ALLOC;
    if (roll < 44) return OP_FREE;
    if (roll < 58) return OP_INC;
    if (roll < 68) return OP_READ;
    if (roll < 93) return OP_DONATE;
    if (roll < 96) return OP_RSVD_FIRST + OPC_W'($urandom_range(OP_RSVD_LAST - OP_RSVD_FIRST));
    return OP_ALLOC;
  endfunction

  // Favor recently granted and low frames so requests hit live state
  function automatic logic [FN_W-1:0] pick_frame();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) return '1;
    if (roll < 7) return FN_W'($urandom_range(2 ** FN_W - 1, NUM_FRAMES));
    if (roll < 40 && sb.granted_log.size() != 0)
      return FN_W'(sb.granted_log[$urandom_range(sb.granted_log.size() - 1)]);
    if (roll < 72) return FN_W'($urandom_range(15));
    return FN_W'($urandom_range(NUM_FRAMES - 1));
  endfunction

  task automatic run_random_traffic(input int unsigned items);
    logic [OPC_W-1:0] op;
    for (int unsigned i = 0; i < items; i++) begin
      op = pick_opcode();
      send_req(op, (op == OP_ALLOC) ? FN_W'($urandom) : pick_frame());
      if ($urandom_range(99) < 2) wait_results_drained();
    end
  endtask

  initial begin
    sb                 = new();
    rst_n              = 1'b0;
    steady             = 1'b0;
    stall_cycles       = 0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_ALLOC;
    in_ch.frame_number = '0;
    out_ch.ready       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty stack, range and opcode corners, count edge cases
    send_req(OP_ALLOC, '0);
    send_req(OP_READ, 20'd0);
    send_req(OP_FREE, 20'd0);
    send_req(OP_DONATE, FN_W'(NUM_FRAMES));
    send_req(OP_FREE, '1);
    send_req(OP_INC, FN_W'(NUM_FRAMES));
    send_req(OP_READ, '1);
    send_req(OP_RSVD_FIRST, 20'd0);
    send_req(OP_RSVD_FIRST + 3'd1, '1);
    send_req(OP_RSVD_LAST, 20'h55555);
    send_req(OP_DONATE, 20'd0);
    send_req(OP_DONATE, 20'd0);
    send_req(OP_DONATE, FN_W'(NUM_FRAMES - 1));
    // donated frame keeps its count; dropping it to zero pushes nothing
    send_req(OP_INC, 20'd7);
    send_req(OP_DONATE, 20'd7);
    send_req(OP_FREE, 20'd7);
    send_req(OP_ALLOC, '1);
    send_req(OP_INC, 20'd7);
    send_req(OP_FREE, 20'd7);
    send_req(OP_FREE, 20'd7);
    send_req(OP_ALLOC, 20'hAAAAA);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_READ, FN_W'(NUM_FRAMES - 1));

    // Raise a count on a frame never donated, then lower it by one
    repeat (3) send_req(OP_INC, 20'd3);
    send_req(OP_FREE, 20'd3);

    run_random_traffic(250);
    wait_results_drained();

    // Empty the stack, then one alloc more on the empty stack
    fill_allocs = sb.depth;
    repeat (fill_allocs) send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);

    steady = 1'b1;
    run_random_traffic(150);
    steady = 1'b0;
    run_random_traffic(200);
    wait_results_drained();

    $display("Run covered %0d requests and %0d results: corner cases, range and opcode errors,",
             sb.requests, sb.results);
    $display("an emptied free stack, stall-free and stalled random traffic.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
